/* rtl/lqfp_pkg.sv */
package lqfp_pkg;

  // Framing byte used for both header and trailer
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  // Frame type that carries the link quality report
  localparam logic [7:0] LINK_TYPE = 8'hFE;
  // Data bytes per frame, and how many of them are kept
  localparam logic [2:0] DATA_LEN  = 3'd7;
  localparam logic [2:0] KEEP_LEN  = 3'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TYPE    = 2'd1,
    PH_DATA    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

endpackage

/* rtl/link_quality_frame_parser.sv */
// Byte-serial parser for 11-byte telemetry host frames.
//
// Input channel (in_valid / in_ready / rx_byte): one received byte per
// transaction. Output channel (out_valid / out_ready / frame_type,
// is_link_packet, adc_one, adc_two, link_quality): one transaction per
// frame that closes with a good 0x7E trailer. A bad trailer drops the frame
// silently; either way the parser goes back to hunting for a header.
//
// The result is registered: it appears on the output register in the cycle
// after the trailer byte is accepted. Throughput: one byte per cycle while no
// result waits unread; the frame state advances in a single pass of logic
// between the input handshake and the state and result registers.
//
// Reset (rst, synchronous, active high) returns the parser to header hunt
// and empties the output register. When the receiver stalls, the pending
// result holds; bytes keep flowing while the output register is empty or
// being drained in the same cycle, and only the trailer-to-result path
// needs the slot, so in_ready drops only while a result waits unread.
module link_quality_frame_parser
  import lqfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_type,
  output logic       is_link_packet,
  output logic [7:0] adc_one,
  output logic [7:0] adc_two,
  output logic [7:0] link_quality
);

  phase_t      phase;
  phase_t      phase_next;
  logic [2:0]  byte_count;
  logic [2:0]  byte_count_next;
  logic [7:0]  type_reg;
  logic [7:0]  payload_store [KEEP_LEN];

  logic        in_fire;
  logic        is_flag;
  logic        load_type;
  logic        store_data;
  logic        emit;

  // Accept a byte whenever the result slot is free or emptying now
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_flag  = (rx_byte == FLAG_BYTE);

  // Next-state logic for the frame phase and data counter
  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    if (in_fire) begin
      unique case (phase)
        PH_HEADER: begin
          if (is_flag) begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          // Skip repeated headers; any other byte is the frame type
          if (!is_flag) begin
            byte_count_next = '0;
            phase_next      = PH_DATA;
          end
        end
        PH_DATA: begin
          // After seven data bytes, drop the spare byte and expect trailer
          if (byte_count != DATA_LEN) begin
            byte_count_next = byte_count + 3'd1;
          end else begin
            phase_next = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          phase_next = PH_HEADER;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  // Datapath controls decoded from the current phase
  always_comb begin
    load_type  = 1'b0;
    store_data = 1'b0;
    emit       = 1'b0;
    if (in_fire) begin
      unique case (phase)
        PH_HEADER: begin
        end
        PH_TYPE: begin
          load_type = !is_flag;
        end
        PH_DATA: begin
          store_data = (byte_count < KEEP_LEN);
        end
        PH_TRAILER: begin
          emit = is_flag;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      byte_count <= '0;
      type_reg   <= '0;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      if (load_type) begin
        type_reg <= rx_byte;
      end
    end
  end

  // Keep the first three data bytes of the frame
  always_ff @(posedge clk) begin
    if (store_data) begin
      payload_store[byte_count[1:0]] <= rx_byte;
    end
  end

  // Result register: load on a good trailer, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_type     <= type_reg;
      is_link_packet <= (type_reg == LINK_TYPE);
      adc_one        <= payload_store[0];
      adc_two        <= payload_store[1];
      link_quality   <= payload_store[2];
    end
  end

  // The trailer phase is only reached after all seven data bytes
  a_trailer_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRAILER) |-> (byte_count == DATA_LEN))
    else $error("trailer phase entered with incomplete data count");

  // A good trailer byte always produces a result
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_TRAILER && is_flag) |=> out_valid)
    else $error("good trailer did not produce a result");

  // The link flag always agrees with the reported frame type
  a_link_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_link_packet == (frame_type == LINK_TYPE)))
    else $error("link packet flag disagrees with frame type");

  // Each accepted data byte below the limit advances the counter by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_DATA && byte_count != DATA_LEN)
      |=> (byte_count == $past(byte_count) + 3'd1))
    else $error("data byte counter did not advance");

endmodule

/* dv/link_quality_frame_parser_test.sv */
module link_quality_frame_parser_test;
  import lqfp_pkg::*;

  // Watchdog limit: cycles in a row with no transaction on either channel.
  // The longest quiet stretch in a correct run is the receiver hold-off
  // (HOLD_CYCLES) plus a sender gap.
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_START   = 400;
  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_BYTES = 500;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] frame_type;
  logic       is_link_packet;
  logic [7:0] adc_one;
  logic [7:0] adc_two;
  logic [7:0] link_quality;

  typedef struct packed {
    logic [7:0] frame_type;
    logic       is_link;
    logic [7:0] adc_one;
    logic [7:0] adc_two;
    logic [7:0] link_quality;
  } frame_report_t;

  // Frame tracker: follows the header / type / data / trailer walk on every
  // accepted byte and queues the report that a good trailer produces.
  class frame_scoreboard;
    phase_t        parse_phase;
    logic [2:0]    data_cnt;
    logic [7:0]    type_held;
    logic [7:0]    kept[3];
    frame_report_t expected_frames[$];
    int            errors;

    function new();
      parse_phase = PH_HEADER;
      data_cnt    = '0;
      type_held   = '0;
      errors      = 0;
      foreach (kept[i]) kept[i] = '0;
    endfunction

    function void take_byte(logic [7:0] b);
      frame_report_t rep;
      case (parse_phase)
        PH_HEADER: begin
          if (b == FLAG_BYTE) parse_phase = PH_TYPE;
        end
        PH_TYPE: begin
          // a repeated flag in the type slot keeps us waiting for the type
          if (b != FLAG_BYTE) begin
            type_held   = b;
            data_cnt    = '0;
            parse_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_cnt < DATA_LEN) begin
            if (data_cnt < KEEP_LEN) kept[data_cnt[1:0]] = b;
            data_cnt = data_cnt + 3'd1;
          end else begin
            // byte after the seven data bytes is dropped
            parse_phase = PH_TRAILER;
          end
        end
        default: begin
          parse_phase = PH_HEADER;
          if (b == FLAG_BYTE) begin
            rep.frame_type   = type_held;
            rep.is_link      = (type_held == LINK_TYPE);
            rep.adc_one      = kept[0];
            rep.adc_two      = kept[1];
            rep.link_quality = kept[2];
            expected_frames.push_back(rep);
          end
        end
      endcase
    endfunction

    function void report(string what, frame_report_t exp, frame_report_t got);
      errors++;
      if (errors <= 10) begin
        $display("mismatch (%s): exp type=%h link=%b adc1=%h adc2=%h lq=%h",
                 what, exp.frame_type, exp.is_link, exp.adc_one, exp.adc_two,
                 exp.link_quality);
        $display("  got type=%h link=%b adc1=%h adc2=%h lq=%h",
                 got.frame_type, got.is_link, got.adc_one, got.adc_two,
                 got.link_quality);
      end
    endfunction

    function void check_frame(frame_report_t got);
      frame_report_t exp;
      if (expected_frames.size() == 0) begin
        report("no frame expected", '0, got);
      end else begin
        exp = expected_frames.pop_front();
        if (got.frame_type !== exp.frame_type || got.is_link !== exp.is_link ||
            got.adc_one !== exp.adc_one || got.adc_two !== exp.adc_two ||
            got.link_quality !== exp.link_quality)
          report("field", exp, got);
      end
    endfunction
  endclass

  frame_scoreboard sb = new();

  int burst_left = 1;
  int rx_cycle   = 0;
  int idle_run   = 0;
  int random_cnt = 0;

  link_quality_frame_parser uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_type    (frame_type),
    .is_link_packet(is_link_packet),
    .adc_one       (adc_one),
    .adc_two       (adc_two),
    .link_quality  (link_quality)
  );

  always #5 clk = ~clk;

  // Offer one byte and hold it until the transaction completes. Between
  // bursts, drop valid for a random gap; a zero gap keeps valid high so
  // back-to-back bytes flow with no idle cycle.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Send one frame: optional extra flags ahead of the type, seven random data
  // bytes, the dropped extra byte, then a good or bad trailer.
  task automatic send_frame(input logic [7:0] ftype, input int extra_flags,
                            input bit good_trailer);
    logic [7:0] tail;
    send_byte(FLAG_BYTE);
    repeat (extra_flags) send_byte(FLAG_BYTE);
    send_byte(ftype);
    repeat (int'(DATA_LEN) + 1) send_byte(8'($urandom_range(0, 255)));
    tail = 8'($urandom_range(0, 255));
    if (tail == FLAG_BYTE) tail = 8'h00;
    send_byte(good_trailer ? FLAG_BYTE : tail);
    random_cnt += int'(DATA_LEN) + 4 + extra_flags;
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0 || t == FLAG_BYTE) t = LINK_TYPE;
    return t;
  endfunction

  // Drive the stimulus: a short directed pass, then mostly well-formed
  // frames with random content mixed with noise and broken frames.
  initial begin
    logic [7:0] directed[$];
    int         kind;
    int         cut;
    directed = '{
      8'h00,                                     // noise while hunting
      FLAG_BYTE, FLAG_BYTE, LINK_TYPE,           // repeated header, link type
      8'h00, 8'hFF, 8'h55, 8'hAA, 8'h12, 8'h34, 8'h56,
      8'hFF,                                     // extra byte, dropped
      FLAG_BYTE,                                 // good trailer
      FLAG_BYTE, 8'h00,                          // type zero
      8'hFF, 8'h00, FLAG_BYTE, 8'h01, 8'h02, 8'h03, 8'h04,
      8'h7F,                                     // extra byte
      8'hFF                                      // bad trailer, no frame
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i]);
    send_frame(8'hFF, 0, 1'b1);

    while (random_cnt < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_frame(pick_type(), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0,
                   1'b1);
      end else if (kind == 7) begin
        send_frame(pick_type(), 0, 1'b0);
      end else if (kind == 8) begin
        // cut a frame short; the next header lands mid-frame
        cut = $urandom_range(0, 8);
        send_byte(FLAG_BYTE);
        send_byte(pick_type());
        repeat (cut) send_byte(8'($urandom_range(0, 255)));
        random_cnt += cut + 2;
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    // Drain: the watchdog ends the run if a frame never shows up.
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: switch at random between stall patterns, and once hold
  // ready low for a long stretch so the output register fills and in_ready
  // drops while the sender keeps offering bytes.
  initial begin
    int mode;
    mode = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 50 == 0) mode = $urandom_range(0, 2);
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
        out_ready <= 1'b0;
      else if (mode == 0)
        out_ready <= 1'b1;
      else if (mode == 1)
        out_ready <= 1'($urandom_range(0, 1));
      else
        out_ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Check every output transaction against the oldest expected frame.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_frame('{frame_type, is_link_packet, adc_one, adc_two, link_quality});
  end

  // Watchdog: advance on idle cycles, clear on any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

/* link_quality_frame_parser.f */
rtl/lqfp_pkg.sv
rtl/link_quality_frame_parser.sv
dv/link_quality_frame_parser_test.sv
